### design/shc_pkg.sv
// Shared types and codes for the SECDED Hamming codec.
// Holds the channel payload structs, command and status codes.
// No dependencies.
package shc_pkg;

    // Widths of the channel fields.
    localparam int WORD_W              = 64;
    localparam int CHECK_W             = 3;
    localparam int STATUS_W            = 2;
    localparam int MAX_CHECK_BITS_DEF  = 6;
    localparam int MIN_CHECK_BITS      = 2;

    // Command codes.
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CORRECTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DOUBLE    = 2'd2;

    // Input transfer payload.
    typedef struct packed {
        logic                command;
        logic [CHECK_W-1:0]  check_bits;
        logic [WORD_W-1:0]   word_in;
    } shc_in_t;

    // Result transfer payload.
    typedef struct packed {
        logic [WORD_W-1:0]   word_out;
        logic [STATUS_W-1:0] status;
    } shc_out_t;

endpackage

### design/secded_hamming_codec_unit.sv
// Throughput: one item per cycle while m_ready holds; each stage holds one item and
// moves on when the stage after it is empty or moving, so a waiting result stalls
// the input only once all four stages are full.
// Reset: aresetn (synchronous, active low) clears the stage valid bits only.
// Top level of the extended Hamming SECDED codec; depends on shc_pkg.
module secded_hamming_codec_unit #(
    parameter int MAX_CHECK_BITS = shc_pkg::MAX_CHECK_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  shc_pkg::shc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output shc_pkg::shc_out_t m_data
);
    import shc_pkg::*;

    localparam int CW_W  = 1 << MAX_CHECK_BITS;
    localparam int CNT_W = MAX_CHECK_BITS + 1;

    // True for one-based positions that hold parity bits.
    function automatic logic is_pow2(input int p);
        return (p & (p - 1)) == 0;
    endfunction

    // Codeword bits whose one-based position has bit i set.
    function automatic logic [CW_W-1:0] pos_mask(input int i);
        logic [CW_W-1:0] m;
        m = '0;
        for (int p = 1; p < CW_W; p++) begin
            m[p-1] = ((p >> i) & 1) != 0;
        end
        return m;
    endfunction

    // Place data bits, LSB first, at the non-parity positions.
    function automatic logic [CW_W-1:0] scatter_data(input logic [CW_W-1:0] d);
        logic [CW_W-1:0] cw;
        int              idx;
        cw  = '0;
        idx = 0;
        for (int p = 1; p < CW_W; p++) begin
            if (!is_pow2(p)) begin
                cw[p-1] = d[idx];
                idx++;
            end
        end
        return cw;
    endfunction

    // Pull the data bits back out of the non-parity positions.
    function automatic logic [CW_W-1:0] gather_data(input logic [CW_W-1:0] cw);
        logic [CW_W-1:0] d;
        int              idx;
        d   = '0;
        idx = 0;
        for (int p = 1; p < CW_W; p++) begin
            if (!is_pow2(p)) begin
                d[idx] = cw[p-1];
                idx++;
            end
        end
        return d;
    endfunction

    // Mask of the low cnt bits; a count equal to CW_W wraps to all ones.
    function automatic logic [CW_W-1:0] low_ones(input logic [CNT_W-1:0] cnt);
        return (CW_W'(1) << cnt) - CW_W'(1);
    endfunction

    // Codeword length 2^r for a clamped r.
    function automatic logic [CNT_W-1:0] cw_len(input logic [CHECK_W-1:0] r);
        return CNT_W'(1) << r;
    endfunction

    // Stage handshake: a stage moves when it is empty or the next one moves.
    logic adv1, adv2, adv3, adv4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign adv4    = !v4_reg || m_ready;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: clamp r, mask the input word and scatter data for encode.
    logic [CHECK_W-1:0] r_next, r1_reg, r2_reg;
    logic [CNT_W-1:0]   n1_len, k1_len;
    logic [CW_W-1:0]    w1_next, w1_reg;
    logic               cmd1_reg, cmd2_reg, cmd3_reg, cmd4_reg;

    always_comb begin
        if (s_data.check_bits < CHECK_W'(MIN_CHECK_BITS)) begin
            r_next = CHECK_W'(MIN_CHECK_BITS);
        end else if (s_data.check_bits > CHECK_W'(MAX_CHECK_BITS)) begin
            r_next = CHECK_W'(MAX_CHECK_BITS);
        end else begin
            r_next = s_data.check_bits;
        end
        n1_len = cw_len(r_next);
        k1_len = n1_len - CNT_W'(r_next) - CNT_W'(1);
        if (s_data.command == CMD_DECODE) begin
            w1_next = s_data.word_in[CW_W-1:0] & low_ones(n1_len);
        end else begin
            w1_next = scatter_data(s_data.word_in[CW_W-1:0] & low_ones(k1_len));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            r1_reg   <= r_next;
            cmd1_reg <= s_data.command;
            w1_reg   <= w1_next;
        end
    end

    // Stage 2: syndrome over all but the top bit, and parity of the whole word.
    logic [MAX_CHECK_BITS-1:0] syn_next, syn2_reg;
    logic [CW_W-1:0]           syn_mask, w2_reg;
    logic                      par2_reg;

    always_comb begin
        syn_mask = low_ones(cw_len(r1_reg)) >> 1;
        for (int i = 0; i < MAX_CHECK_BITS; i++) begin
            syn_next[i] = ^(w1_reg & pos_mask(i) & syn_mask);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            r2_reg   <= r1_reg;
            cmd2_reg <= cmd1_reg;
            w2_reg   <= w1_reg;
            syn2_reg <= syn_next;
            par2_reg <= ^w1_reg;
        end
    end

    // Stage 3: insert parity bits for encode, or correct and classify for decode.
    logic [CW_W-1:0]     n2_mask, top_vec, flip_vec, w3_next, w3_reg;
    logic [STATUS_W-1:0] status_next, status3_reg;

    always_comb begin
        n2_mask     = low_ones(cw_len(r2_reg));
        top_vec     = n2_mask ^ (n2_mask >> 1);
        flip_vec    = (CW_W'(1) << syn2_reg) >> 1;
        w3_next     = w2_reg;
        status_next = STATUS_OK;
        if (cmd2_reg == CMD_ENCODE) begin
            for (int i = 0; i < MAX_CHECK_BITS; i++) begin
                w3_next[(1 << i) - 1] = syn2_reg[i];
            end
            // Overall parity is data parity plus the parity of the check bits.
            w3_next = w3_next | (top_vec & {CW_W{par2_reg ^ (^syn2_reg)}});
        end else if (par2_reg) begin
            status_next = STATUS_CORRECTED;
            w3_next     = w2_reg ^ flip_vec;
        end else if (syn2_reg != '0) begin
            status_next = STATUS_DOUBLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            cmd3_reg    <= cmd2_reg;
            w3_reg      <= w3_next;
            status3_reg <= status_next;
        end
    end

    // Stage 4: extract data for decode and hold the result.
    shc_out_t out_next, out_reg;

    always_comb begin
        out_next.status = status3_reg;
        if (cmd3_reg == CMD_DECODE) begin
            out_next.word_out = WORD_W'(gather_data(w3_reg));
        end else begin
            out_next.word_out = WORD_W'(w3_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            cmd4_reg <= cmd3_reg;
            out_reg  <= out_next;
        end
    end

    // Encode results always carry a clean status.
    assign m_data.word_out = out_reg.word_out;
    assign m_data.status   = (cmd4_reg == CMD_ENCODE) ? STATUS_OK : out_reg.status;

endmodule

### design/shc_checker.sv
// Port-level checker for the SECDED Hamming codec, with its bind statement.
// Depends on shc_pkg and on the top level secded_hamming_codec_unit.
module shc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input shc_pkg::shc_out_t m_data
);
    import shc_pkg::*;

    // A held result keeps its value until the transfer completes.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With no result waiting, nothing inside can stall the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // An accepted item reaches the output through the stage registers when never stalled.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && m_ready ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("result missing after pipeline latency");

    // Status never carries the unused code.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status == STATUS_OK || m_data.status == STATUS_CORRECTED
                    || m_data.status == STATUS_DOUBLE)
        else $error("unused status code");

endmodule

bind secded_hamming_codec_unit shc_checker u_shc_checker (.*);

### tb/secded_hamming_codec_unit_tb.sv
// Self-checking testbench for the extended Hamming SECDED codec unit.
// Depends on shc_pkg and secded_hamming_codec_unit; prediction runs in a scoreboard class.
`timescale 1ns / 100ps

module tb;
    import shc_pkg::*;

    // Scoreboard: predicts each accepted input and checks results in order.
    class secded_scoreboard;
        shc_out_t expected_q[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // XOR of the one-based positions of all set bits below the top bit.
        function int unsigned position_xor(logic [WORD_W-1:0] cw, int unsigned n);
            int unsigned pos;
            int unsigned syn;
            syn = 0;
            for (pos = 1; pos < n; pos++) begin
                if (cw[pos-1]) begin
                    syn = syn ^ pos;
                end
            end
            return syn;
        endfunction

        // Computes the codec result for one input transfer.
        function shc_out_t predict(shc_in_t item);
            int unsigned     r;
            int unsigned     n;
            int unsigned     pos;
            int unsigned     d;
            int unsigned     syn;
            int unsigned     i;
            logic [WORD_W-1:0] cw;
            logic [WORD_W-1:0] data;
            shc_out_t        res;
            r = item.check_bits;
            if (r < MIN_CHECK_BITS) r = MIN_CHECK_BITS;
            if (r > MAX_CHECK_BITS_DEF) r = MAX_CHECK_BITS_DEF;
            n = 1 << r;
            cw = '0;
            data = '0;
            d = 0;
            res.status = STATUS_OK;
            if (item.command == CMD_ENCODE) begin
                // Data bits fill the positions that are not powers of two.
                for (pos = 1; pos < n; pos++) begin
                    if ((pos & (pos - 1)) != 0) begin
                        cw[pos-1] = item.word_in[d];
                        d++;
                    end
                end
                syn = position_xor(cw, n);
                for (i = 0; i < r; i++) begin
                    cw[(1 << i) - 1] = syn[i];
                end
                cw[n-1] = ^cw;
                res.word_out = cw;
            end else begin
                cw = item.word_in;
                if (n < WORD_W) cw = cw & ((64'd1 << n) - 64'd1);
                syn = position_xor(cw, n);
                if (^cw) begin
                    // Odd parity: a single error, possibly in the overall parity bit.
                    res.status = STATUS_CORRECTED;
                    if (syn != 0) cw[syn-1] = ~cw[syn-1];
                end else if (syn != 0) begin
                    res.status = STATUS_DOUBLE;
                end
                for (pos = 1; pos < n; pos++) begin
                    if ((pos & (pos - 1)) != 0) begin
                        data[d] = cw[pos-1];
                        d++;
                    end
                end
                res.word_out = data;
            end
            return res;
        endfunction

        function void note_input(shc_in_t item);
            expected_q = {expected_q, predict(item)};
        endfunction

        function void check_result(shc_out_t got);
            shc_out_t exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result transfer word_out=%h status=%0d",
                         $time, got.word_out, got.status);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.word_out !== exp_res.word_out) begin
                $display("%0t: word_out mismatch expected=%h actual=%h",
                         $time, exp_res.word_out, got.word_out);
                errors++;
            end
            if (got.status !== exp_res.status) begin
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         $time, exp_res.status, got.status);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    shc_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    shc_out_t m_data;

    secded_scoreboard sb;
    bit               quiet_phase = 1'b0;
    int               calm_left   = 0;

    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_ITEMS  = 60;

    secded_hamming_codec_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // Observe both channels at each rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    function automatic shc_in_t make_item(logic cmd, int unsigned r, logic [WORD_W-1:0] w);
        shc_in_t item;
        item.command    = cmd;
        item.check_bits = r[CHECK_W-1:0];
        item.word_in    = w;
        return item;
    endfunction

    function automatic logic [WORD_W-1:0] codeword(int unsigned r, logic [WORD_W-1:0] data);
        shc_out_t res;
        res = sb.predict(make_item(CMD_ENCODE, r, data));
        return res.word_out;
    endfunction

    function automatic int unsigned clamp_r(int unsigned r);
        if (r < MIN_CHECK_BITS) return MIN_CHECK_BITS;
        if (r > MAX_CHECK_BITS_DEF) return MAX_CHECK_BITS_DEF;
        return r;
    endfunction

    // Offers one input transfer, after an optional random idle burst.
    task automatic send_item(shc_in_t item);
        if (calm_left > 0) begin
            calm_left--;
        end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end else if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 30);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Result side: stall in random bursts until the quiet phase.
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (quiet_phase) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
        end
    end

    // Main stimulus.
    initial begin
        int unsigned       r;
        int unsigned       er;
        int unsigned       n;
        int unsigned       p1;
        int unsigned       p2;
        int unsigned       kind;
        int unsigned       nerr;
        int                i;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] mask;

        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: check_bits outside the legal range are clamped.
        send_item(make_item(CMD_ENCODE, 0, '1));
        send_item(make_item(CMD_ENCODE, 7, '1));
        send_item(make_item(CMD_DECODE, 1, '1));
        send_item(make_item(CMD_ENCODE, 6, '0));

        // Directed: every legal size, clean, parity-bit error and double error.
        for (r = MIN_CHECK_BITS; r <= MAX_CHECK_BITS_DEF; r++) begin
            n = 1 << r;
            mask = (n < WORD_W) ? ((64'd1 << n) - 64'd1) : '1;
            send_item(make_item(CMD_ENCODE, r, '1));
            w = codeword(r, {$urandom, $urandom});
            send_item(make_item(CMD_DECODE, r, w | ~mask));
            send_item(make_item(CMD_DECODE, r, w ^ (64'd1 << ((1 << (r - 2)) - 1))));
            p1 = $urandom_range(0, n - 1);
            p2 = (p1 + $urandom_range(1, n - 1)) % n;
            send_item(make_item(CMD_DECODE, r, w ^ (64'd1 << p1) ^ (64'd1 << p2)));
        end

        // Directed: error in the overall parity bit only.
        w = codeword(4, {$urandom, $urandom});
        send_item(make_item(CMD_DECODE, 4, w ^ (64'd1 << 15)));
        w = codeword(6, {$urandom, $urandom});
        send_item(make_item(CMD_DECODE, 6, w ^ (64'd1 << 63)));

        // Random: half codewords with zero, one or two errors, the rest encodes and some noise.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
            kind = $urandom_range(0, 9);
            r  = $urandom_range(0, 7);
            er = clamp_r(r);
            n  = 1 << er;
            mask = (n < WORD_W) ? ((64'd1 << n) - 64'd1) : '1;
            if (kind < 4) begin
                send_item(make_item(CMD_ENCODE, r, {$urandom, $urandom}));
            end else if (kind < 9) begin
                w = codeword(r, {$urandom, $urandom});
                nerr = $urandom_range(0, 2);
                p1 = $urandom_range(0, n - 1);
                p2 = (p1 + $urandom_range(1, n - 1)) % n;
                if (nerr >= 1) w = w ^ (64'd1 << p1);
                if (nerr == 2) w = w ^ (64'd1 << p2);
                if ($urandom_range(0, 1) == 1) w = w | ({$urandom, $urandom} & ~mask);
                send_item(make_item(CMD_DECODE, r, w));
            end else begin
                send_item(make_item(CMD_DECODE, r, {$urandom, $urandom}));
            end
        end
        s_valid <= 1'b0;

        // Drain the pipeline, then wait for stray results.
        while (sb.pending() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
